FILE: hw/rtl/page_table_walker_unit_defines.svh
// assertion macros for the page table walker
`ifndef PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define PAGE_TABLE_WALKER_UNIT_DEFINES_SVH

// clocked property, masked while reset is high
`define PTW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define PTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ptw_pkg.sv
`timescale 1ns / 1ps

package ptw_pkg;

   localparam int unsigned VA_W    = 48;
   localparam int unsigned PA_W    = 52;
   localparam int unsigned ENTRY_W = 64;
   localparam int unsigned IDX_W   = 9;
   localparam int unsigned PAGE_SH = 12;

   localparam int unsigned BIT_PRESENT = 0;
   localparam int unsigned BIT_SIZE    = 7;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_FAULT = 2'd2,
      KIND_PERR  = 2'd3
   } kind_type;

   typedef enum logic {
      ACT_TRANSLATE = 1'b0,
      ACT_RESPONSE  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      OP_READ,
      OP_DONE_1G,
      OP_DONE_2M,
      OP_DONE_4K,
      OP_FAULT,
      OP_PERR
   } op_type;

   typedef enum logic [1:0] {
      LVL_TOP  = 2'd0,
      LVL_DIR  = 2'd1,
      LVL_MID  = 2'd2,
      LVL_LAST = 2'd3
   } level_type;

   typedef enum logic [1:0] {
      SIZE_4K = 2'd0,
      SIZE_2M = 2'd1,
      SIZE_1G = 2'd2
   } page_size_type;

   typedef struct packed {
      op_type          op;
      logic [PA_W-1:0] frame;
      logic [VA_W-1:0] va;
      logic [1:0]      level;
   } cmd_type;

endpackage

FILE: hw/rtl/ptw_front.sv
`timescale 1ns / 1ps

module ptw_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_action,
   input  logic [ptw_pkg::VA_W-1:0]    req_virt_addr,
   input  logic [ptw_pkg::ENTRY_W-1:0] req_read_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [ptw_pkg::PA_W-1:0]    csr_wdata,
   output logic                    q_push,
   output ptw_pkg::cmd_type        q_cmd,
   input  logic                    q_full
);
   import ptw_pkg::*;

   logic            busy_ff, busy_in;
   logic [1:0]      level_ff, level_in;
   logic [VA_W-1:0] saved_virt_ff, saved_virt_in;
   logic [PA_W-1:0] root_base_ff;
   logic            accept;
   logic            present;
   logic            size_bit;

   assign full      = q_full;
   assign csr_ready = 1'b1;
   assign accept    = push && !q_full;
   assign q_push    = accept;
   assign present   = req_read_data[BIT_PRESENT];
   assign size_bit  = req_read_data[BIT_SIZE];

   // classify the request and advance the walk
   always_comb begin
      busy_in       = busy_ff;
      level_in      = level_ff;
      saved_virt_in = saved_virt_ff;
      q_cmd.op      = OP_PERR;
      q_cmd.frame   = req_read_data[PA_W-1:0];
      q_cmd.va      = saved_virt_ff;
      q_cmd.level   = level_ff;
      priority if (req_action == ACT_TRANSLATE) begin
         if (!busy_ff) begin
            q_cmd.op      = OP_READ;
            q_cmd.frame   = root_base_ff;
            q_cmd.va      = req_virt_addr;
            q_cmd.level   = LVL_TOP;
            busy_in       = 1'b1;
            level_in      = LVL_TOP;
            saved_virt_in = req_virt_addr;
         end
      end else if (!busy_ff) begin
         q_cmd.op = OP_PERR;
      end else if (!present) begin
         q_cmd.op = OP_FAULT;
         busy_in  = 1'b0;
         level_in = LVL_TOP;
      end else if (level_ff == LVL_DIR && size_bit) begin
         q_cmd.op = OP_DONE_1G;
         busy_in  = 1'b0;
         level_in = LVL_TOP;
      end else if (level_ff == LVL_MID && size_bit) begin
         q_cmd.op = OP_DONE_2M;
         busy_in  = 1'b0;
         level_in = LVL_TOP;
      end else if (level_ff == LVL_LAST) begin
         q_cmd.op = OP_DONE_4K;
         busy_in  = 1'b0;
         level_in = LVL_TOP;
      end else begin
         q_cmd.op    = OP_READ;
         q_cmd.level = 2'(level_ff + 2'd1);
         level_in    = 2'(level_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         level_ff      <= LVL_TOP;
         saved_virt_ff <= '0;
         root_base_ff  <= '0;
      end else begin
         if (accept) begin
            busy_ff       <= busy_in;
            level_ff      <= level_in;
            saved_virt_ff <= saved_virt_in;
         end
         if (csr_valid && csr_ready) begin
            root_base_ff <= csr_wdata;
         end
      end
   end

endmodule

FILE: hw/rtl/ptw_queue.sv
`timescale 1ns / 1ps

module ptw_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  ptw_pkg::cmd_type wr_cmd,
   output logic             q_full,
   input  logic             rd_en,
   output ptw_pkg::cmd_type rd_cmd,
   output logic             q_empty
);
   import ptw_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_wr, do_rd;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_cmd  = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_rd) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         unique case ({do_wr, do_rd})
            2'b10:   count_ff <= CNT_W'(count_ff + 1'b1);
            2'b01:   count_ff <= CNT_W'(count_ff - 1'b1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: hw/rtl/ptw_back.sv
`timescale 1ns / 1ps

module ptw_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ptw_pkg::cmd_type         q_cmd,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     empty,
   input  logic                     pop,
   output logic [1:0]               rsp_kind,
   output logic [ptw_pkg::PA_W-1:0] rsp_address,
   output logic [1:0]               rsp_level
);
   import ptw_pkg::*;

   logic            out_valid_ff;
   logic [1:0]      kind_ff, kind_in;
   logic [PA_W-1:0] address_ff, address_in;
   logic [1:0]      level_ff, level_in;
   logic [IDX_W-1:0] idx;
   logic            load;

   assign load  = !q_empty && (!out_valid_ff || pop);
   assign q_pop = load;
   assign empty = !out_valid_ff;

   // table index for the level being read
   always_comb begin
      unique case (q_cmd.level)
         LVL_TOP:  idx = q_cmd.va[47:39];
         LVL_DIR:  idx = q_cmd.va[38:30];
         LVL_MID:  idx = q_cmd.va[29:21];
         default:  idx = q_cmd.va[20:12];
      endcase
   end

   always_comb begin
      kind_in    = KIND_PERR;
      address_in = '0;
      level_in   = '0;
      unique case (q_cmd.op)
         OP_READ: begin
            kind_in    = KIND_READ;
            address_in = {q_cmd.frame[PA_W-1:PAGE_SH], {PAGE_SH{1'b0}}}
                         + PA_W'({idx, 3'b000});
            level_in   = q_cmd.level;
         end
         OP_DONE_1G: begin
            kind_in    = KIND_DONE;
            address_in = {q_cmd.frame[PA_W-1:30], q_cmd.va[29:0]};
            level_in   = SIZE_1G;
         end
         OP_DONE_2M: begin
            kind_in    = KIND_DONE;
            address_in = {q_cmd.frame[PA_W-1:21], q_cmd.va[20:0]};
            level_in   = SIZE_2M;
         end
         OP_DONE_4K: begin
            kind_in    = KIND_DONE;
            address_in = {q_cmd.frame[PA_W-1:PAGE_SH], q_cmd.va[PAGE_SH-1:0]};
            level_in   = SIZE_4K;
         end
         OP_FAULT: begin
            kind_in  = KIND_FAULT;
            level_in = q_cmd.level;
         end
         default: begin
            kind_in = KIND_PERR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         address_ff <= address_in;
         level_ff   <= level_in;
      end
   end

   assign rsp_kind    = kind_ff;
   assign rsp_address = address_ff;
   assign rsp_level   = level_ff;

endmodule

FILE: hw/rtl/page_table_walker_unit.sv
`timescale 1ns / 1ps

// Four-level x86-64 page table walker. Translate requests and memory read
// responses share one input queue port; every request gives exactly one
// result (a read request for the next table entry, a done translation with
// its page size, a not-present fault, or a protocol error). One request is
// taken every cycle while the internal command queue has room. A request
// is written into the command queue and is then computed into the result
// register once that register is free; the result stays on the result
// ports until it is taken. A result left waiting on the ports holds the
// queue, and full rises once QUEUE_DEPTH requests wait behind it. The walk
// state is updated at acceptance, so a response may follow its read request
// on the very next cycle. The root table base may be written only while the
// walker is idle.
module page_table_walker_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_action,
   input  logic [ptw_pkg::VA_W-1:0]    req_virt_addr,
   input  logic [ptw_pkg::ENTRY_W-1:0] req_read_data,
   output logic                        empty,
   input  logic                        pop,
   output logic [1:0]                  rsp_kind,
   output logic [ptw_pkg::PA_W-1:0]    rsp_address,
   output logic [1:0]                  rsp_level,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ptw_pkg::PA_W-1:0]    csr_wdata
);
   import ptw_pkg::*;

   cmd_type fq_cmd;
   cmd_type qb_cmd;
   logic    fq_push;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;

   ptw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_action    (req_action),
      .req_virt_addr (req_virt_addr),
      .req_read_data (req_read_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .q_push        (fq_push),
      .q_cmd         (fq_cmd),
      .q_full        (q_full)
   );

   ptw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fq_push),
      .wr_cmd  (fq_cmd),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_cmd  (qb_cmd),
      .q_empty (q_empty)
   );

   ptw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_cmd       (qb_cmd),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_kind    (rsp_kind),
      .rsp_address (rsp_address),
      .rsp_level   (rsp_level)
   );

endmodule

FILE: hw/rtl/ptw_checker.sv
`timescale 1ns / 1ps

`include "page_table_walker_unit_defines.svh"

module ptw_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     push,
   input logic                     full,
   input logic                     empty,
   input logic                     pop,
   input logic [1:0]               rsp_kind,
   input logic [ptw_pkg::PA_W-1:0] rsp_address,
   input logic [1:0]               rsp_level
);

   `PTW_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> empty, "result pending after reset")

   `PTW_ASSERT(a_hold, clock, reset, (!empty && !pop) |=> (!empty && $stable(rsp_kind) && $stable(rsp_address) && $stable(rsp_level)), "stalled result changed")

   `PTW_ASSERT(a_latency, clock, reset, (push && !full) |-> ##2 !empty, "no result two cycles after request")

   `PTW_ASSERT(a_full_has_rsp, clock, reset, full |-> !empty, "queue full with empty result register")

endmodule

bind page_table_walker_unit ptw_checker u_ptw_checker (
   .clock       (clock),
   .reset       (reset),
   .push        (push),
   .full        (full),
   .empty       (empty),
   .pop         (pop),
   .rsp_kind    (rsp_kind),
   .rsp_address (rsp_address),
   .rsp_level   (rsp_level)
);

FILE: bench/page_table_walker_unit_test.sv
`timescale 1ns / 1ps

module page_table_walker_unit_test;
   import ptw_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_REQS  = 280;
   localparam int BASE_PHASES = 7;

   typedef struct {
      action_type         action;
      logic [VA_W-1:0]    virt;
      logic [ENTRY_W-1:0] entry;
   } walk_req_type;

   typedef struct {
      kind_type        kind;
      logic [PA_W-1:0] address;
      logic [1:0]      level;
   } walk_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic                req_action = 1'b0;
   logic [VA_W-1:0]     req_virt_addr = '0;
   logic [ENTRY_W-1:0]  req_read_data = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic [1:0]          rsp_kind;
   logic [PA_W-1:0]     rsp_address;
   logic [1:0]          rsp_level;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [PA_W-1:0]     csr_wdata = '0;

   // walker state as predicted
   logic [PA_W-1:0]     root_base = '0;
   logic                walk_busy = 1'b0;
   logic [1:0]          walk_lvl = 2'd0;
   logic [VA_W-1:0]     walk_va = '0;

   walk_req_type        pending_reqs[$];
   walk_result_type     walk_results_due[$];
   walk_req_type        driven_req;
   int                  queued_reqs = 0;
   int                  accepted_reqs = 0;
   int                  failures = 0;
   int                  bases_written = 0;
   int                  kind_seen[4] = '{0, 0, 0, 0};
   int                  size_seen[3] = '{0, 0, 0};
   int                  burst_left = 1;
   int                  gap_left = 0;
   int                  pattern_left = 0;
   int                  stall_mode = 0;
   logic [31:0]         stall_bits = '1;
   int                  quiet_cycles = 0;

   page_table_walker_unit dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_action    (req_action),
      .req_virt_addr (req_virt_addr),
      .req_read_data (req_read_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_kind      (rsp_kind),
      .rsp_address   (rsp_address),
      .rsp_level     (rsp_level),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] base,
                                                  input logic [VA_W-1:0] va,
                                                  input int lvl);
      logic [IDX_W-1:0] slot;
      slot = va[VA_W-1-IDX_W*lvl -: IDX_W];
      return {base[PA_W-1:PAGE_SH], {PAGE_SH{1'b0}}} + PA_W'({slot, 3'b000});
   endfunction

   function automatic void walk_step(input walk_req_type rq);
      walk_result_type res;
      res.kind = KIND_PERR;
      res.address = '0;
      res.level = LVL_TOP;
      if (rq.action == ACT_TRANSLATE) begin
         if (!walk_busy) begin
            walk_va = rq.virt;
            walk_busy = 1'b1;
            walk_lvl = LVL_TOP;
            res.kind = KIND_READ;
            res.address = entry_addr(root_base, rq.virt, LVL_TOP);
         end
      end else if (walk_busy) begin
         if (!rq.entry[BIT_PRESENT]) begin
            res.kind = KIND_FAULT;
            res.level = walk_lvl;
            walk_busy = 1'b0;
            walk_lvl = LVL_TOP;
         end else if (walk_lvl == LVL_DIR && rq.entry[BIT_SIZE]) begin
            res.kind = KIND_DONE;
            res.address = {rq.entry[PA_W-1:30], walk_va[29:0]};
            res.level = SIZE_1G;
            walk_busy = 1'b0;
            walk_lvl = LVL_TOP;
         end else if (walk_lvl == LVL_MID && rq.entry[BIT_SIZE]) begin
            res.kind = KIND_DONE;
            res.address = {rq.entry[PA_W-1:21], walk_va[20:0]};
            res.level = SIZE_2M;
            walk_busy = 1'b0;
            walk_lvl = LVL_TOP;
         end else if (walk_lvl == LVL_LAST) begin
            res.kind = KIND_DONE;
            res.address = {rq.entry[PA_W-1:PAGE_SH], walk_va[PAGE_SH-1:0]};
            res.level = SIZE_4K;
            walk_busy = 1'b0;
            walk_lvl = LVL_TOP;
         end else begin
            walk_lvl = walk_lvl + 2'd1;
            res.kind = KIND_READ;
            res.address = entry_addr(rq.entry[PA_W-1:0], walk_va, walk_lvl);
            res.level = walk_lvl;
         end
      end
      walk_results_due.push_back(res);
   endfunction

   function automatic logic [63:0] rand_bits();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r;
   endfunction

   function automatic logic [ENTRY_W-1:0] rand_entry(input logic present, input logic huge);
      logic [ENTRY_W-1:0] e;
      e = rand_bits();
      e[BIT_PRESENT] = present;
      e[BIT_SIZE] = huge;
      return e;
   endfunction

   task automatic queue_translate(input logic [VA_W-1:0] va);
      walk_req_type rq;
      rq.action = ACT_TRANSLATE;
      rq.virt = va;
      rq.entry = rand_bits();
      pending_reqs.push_back(rq);
      queued_reqs++;
   endtask

   task automatic queue_entry(input logic [ENTRY_W-1:0] e);
      walk_req_type rq;
      logic [63:0] r;
      r = rand_bits();
      rq.action = ACT_RESPONSE;
      rq.virt = r[VA_W-1:0];
      rq.entry = e;
      pending_reqs.push_back(rq);
      queued_reqs++;
   endtask

   task automatic queue_random_walks(input int target);
      int first;
      int lvl;
      logic [63:0] r;
      logic done;
      first = queued_reqs;
      while (queued_reqs - first < target) begin
         // stray response while idle
         if ($urandom_range(0, 15) == 0)
            queue_entry(rand_entry(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         r = rand_bits();
         queue_translate(r[VA_W-1:0]);
         done = 1'b0;
         for (lvl = LVL_TOP; lvl <= LVL_LAST && !done; lvl++) begin
            // translate while a walk is in progress
            if ($urandom_range(0, 15) == 0) begin
               r = rand_bits();
               queue_translate(r[VA_W-1:0]);
            end
            if ($urandom_range(0, 9) == 0) begin
               queue_entry(rand_entry(1'b0, 1'($urandom_range(0, 1))));
               done = 1'b1;
            end else if ((lvl == LVL_DIR || lvl == LVL_MID) && $urandom_range(0, 2) == 0) begin
               queue_entry(rand_entry(1'b1, 1'b1));
               done = 1'b1;
            end else if (lvl == LVL_DIR || lvl == LVL_MID) begin
               queue_entry(rand_entry(1'b1, 1'b0));
            end else begin
               queue_entry(rand_entry(1'b1, 1'($urandom_range(0, 1))));
            end
         end
      end
   endtask

   task automatic drain_walks();
      do @(posedge clock);
      while (accepted_reqs != queued_reqs || walk_results_due.size() != 0);
   endtask

   task automatic write_root_base(input logic [PA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      root_base = value;
      bases_written++;
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin : driver
      walk_req_type nxt;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            walk_step(driven_req);
            accepted_reqs++;
         end
         if (!push || !full) begin
            if (gap_left != 0) begin
               gap_left--;
               push <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               driven_req = nxt;
               push <= 1'b1;
               req_action <= (nxt.action == ACT_RESPONSE);
               req_virt_addr <= nxt.virt;
               req_read_data <= nxt.entry;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 60);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      walk_result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            kind_seen[rsp_kind]++;
            if (rsp_kind == KIND_DONE && rsp_level <= SIZE_1G)
               size_seen[rsp_level]++;
            if (walk_results_due.size() == 0) begin
               $error("result with no request pending: kind %0d address %h level %0d",
                      rsp_kind, rsp_address, rsp_level);
               failures++;
            end else begin
               want = walk_results_due.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  failures++;
               end
               if (rsp_address !== want.address) begin
                  $error("address: expected %h, got %h", want.address, rsp_address);
                  failures++;
               end
               if (rsp_level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, rsp_level);
                  failures++;
               end
            end
         end
         if (pattern_left <= 0) begin
            pattern_left = $urandom_range(8, 96);
            stall_mode = $urandom_range(0, 3);
            stall_bits = $urandom;
         end
         pattern_left--;
         case (stall_mode)
            0: begin
               pop <= 1'b1;
            end
            1: begin
               pop <= stall_bits[pattern_left % 32];
            end
            2: begin
               pop <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               pop <= 1'($urandom_range(0, 1));
            end
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[page_table_walker_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin : stimulus
      logic [63:0] r;
      int ph;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed walks under the reset root base
      queue_entry('1);
      queue_translate('1);
      queue_translate(48'h0);
      queue_entry('1);
      queue_entry('1);
      queue_translate(48'h0);
      queue_entry(64'h1);
      queue_entry(64'hFFFF_FFFF_FFFF_FF7F);
      queue_entry('1);
      queue_translate(48'hA5A5_5A5A_F0F0);
      queue_entry(64'h8000_0000_0000_0081);
      queue_entry(64'h0000_0000_0000_0001);
      queue_entry(64'h0000_0000_0000_0001);
      queue_entry('1);
      queue_translate(48'h0000_FFFF_FFFF);
      queue_entry(64'hFFFF_FFFF_FFFF_FFFE);
      queue_translate(48'hFFFF_0000_0000);
      queue_entry(64'h1);
      queue_entry(64'h1);
      queue_entry(64'h1);
      queue_entry(64'hFFFF_FFFF_FFFF_FFFE);
      drain_walks();

      for (ph = 0; ph < BASE_PHASES; ph++) begin
         r = rand_bits();
         case (ph)
            0: write_root_base('1);
            1: write_root_base('0);
            2: write_root_base({{(PA_W-PAGE_SH){1'b0}}, {PAGE_SH{1'b1}}});
            default: write_root_base(r[PA_W-1:0]);
         endcase
         queue_random_walks(PHASE_REQS);
         drain_walks();
      end

      repeat (4) @(posedge clock);
      $display("%0d requests under %0d root bases: %0d reads, %0d faults, %0d protocol errors",
               accepted_reqs, bases_written + 1, kind_seen[KIND_READ], kind_seen[KIND_FAULT],
               kind_seen[KIND_PERR]);
      $display("translations done: %0d of 4K, %0d of 2M, %0d of 1G pages",
               size_seen[SIZE_4K], size_seen[SIZE_2M], size_seen[SIZE_1G]);
      if (failures == 0 && walk_results_due.size() == 0) begin
         $display("[page_table_walker_unit] OK");
      end else begin
         $display("[page_table_walker_unit] ERROR");
      end
      $finish;
   end

endmodule
